>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the character class compiler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CCSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define CCSC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> hw/rtl/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// Character class compiler package
// Shared widths, character constants, types and set helper functions.
// ----------------------------------------------------------------------------
package ccsc_pkg;

	localparam int unsigned UNIT_W = 16;
	localparam int unsigned SET_W  = 94;
	localparam int unsigned LOW_W  = 64;
	localparam int unsigned HIGH_W = SET_W - LOW_W;
	localparam int unsigned OFF_W  = 7;
	localparam int unsigned CNT_W  = 7;

	localparam logic [UNIT_W-1:0] FIRST_CHAR = 16'h0021;
	localparam logic [UNIT_W-1:0] LAST_CHAR  = 16'h007E;
	localparam logic [UNIT_W-1:0] DASH_CHAR  = 16'h002D;
	localparam logic [UNIT_W-1:0] ESC_CHAR   = 16'h005C;
	localparam logic [UNIT_W-1:0] END_CHAR   = 16'h0000;
	localparam logic [OFF_W-1:0]  LAST_OFF   = 7'd93;
	localparam logic [OFF_W-1:0]  DASH_OFF   = 7'd12;

	typedef enum logic [2:0] {
		M_FIRST     = 3'd0,
		M_FIRST_ESC = 3'd1,
		M_MAIN      = 3'd2,
		M_MAIN_ESC  = 3'd3,
		M_DASH1     = 3'd4,
		M_DASHN     = 3'd5,
		M_RANGE_ESC = 3'd6,
		M_ERROR     = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_REVERSED = 2'd2,
		ST_DANGLING = 2'd3
	} status_t;

	typedef struct packed {
		logic [LOW_W-1:0]  set_low;
		logic [HIGH_W-1:0] set_high;
		logic [CNT_W-1:0]  member_count;
		status_t           status;
	} result_t;

	// Offsets lo to hi inclusive, with lo <= hi <= 93.
	function automatic logic [SET_W-1:0] range_mask(
		input logic [OFF_W-1:0] lo,
		input logic [OFF_W-1:0] hi
	);
		return ({SET_W{1'b1}} >> (LAST_OFF - hi)) & ({SET_W{1'b1}} << lo);
	endfunction

	function automatic logic [CNT_W-1:0] count_members(input logic [SET_W-1:0] s);
		logic [95:0] v;
		logic [3:0]  c8 [12];
		logic [4:0]  c16 [6];
		logic [5:0]  c32 [3];
		v = {2'b00, s};
		for (int i = 0; i < 12; i++) begin
			c8[i] = 4'd0;
			for (int j = 0; j < 8; j++) begin
				c8[i] = c8[i] + {3'd0, v[8*i+j]};
			end
		end
		for (int i = 0; i < 6; i++) begin
			c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
		end
		for (int i = 0; i < 3; i++) begin
			c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
		end
		return {1'b0, c32[0]} + {1'b0, c32[1]} + {1'b0, c32[2]};
	endfunction

endpackage

>>> hw/rtl/ccsc_parser.sv
// ----------------------------------------------------------------------------
// Spec parser
// Holds the parse state and member set, and steps them by one code unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccsc_parser
	import ccsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [UNIT_W-1:0] code_unit,
	output logic              finish,
	output result_t           result
);

	mode_t              mode_q, mode_d;
	logic [SET_W-1:0]   members_q, members_d;
	logic [OFF_W-1:0]   prev_q, prev_d;
	status_t            err_q, err_d;

	logic               is_end, is_dash, is_esc, is_print, reversed;
	logic [OFF_W-1:0]   off;
	logic               add_en, fin_dash;
	logic [OFF_W-1:0]   add_lo, add_hi;
	status_t            fin_status;
	logic [SET_W-1:0]   fin_set;

	assign is_end   = (code_unit == END_CHAR);
	assign is_dash  = (code_unit == DASH_CHAR);
	assign is_esc   = (code_unit == ESC_CHAR);
	assign is_print = (code_unit >= FIRST_CHAR) && (code_unit <= LAST_CHAR);
	assign off      = code_unit[OFF_W-1:0] - FIRST_CHAR[OFF_W-1:0];
	assign reversed = (prev_q > off);
	assign finish   = is_end;

	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			M_FIRST: begin
				if (is_end) mode_d = M_FIRST;
				else if (is_esc) mode_d = M_FIRST_ESC;
				else if (is_print) mode_d = M_MAIN;
				else mode_d = M_ERROR;
			end
			M_FIRST_ESC, M_MAIN_ESC: begin
				if (is_end) mode_d = M_FIRST;
				else if (is_print) mode_d = M_MAIN;
				else mode_d = M_ERROR;
			end
			M_MAIN: begin
				if (is_end) mode_d = M_FIRST;
				else if (is_dash) mode_d = M_DASH1;
				else if (is_esc) mode_d = M_MAIN_ESC;
				else if (is_print) mode_d = M_MAIN;
				else mode_d = M_ERROR;
			end
			M_DASH1, M_DASHN: begin
				if (is_dash) mode_d = M_DASHN;
				else if (is_end) mode_d = M_FIRST;
				else if (is_esc) mode_d = M_RANGE_ESC;
				else if (is_print && !reversed) mode_d = M_MAIN;
				else mode_d = M_ERROR;
			end
			M_RANGE_ESC: begin
				if (is_end) mode_d = M_FIRST;
				else if (is_print && !reversed) mode_d = M_MAIN;
				else mode_d = M_ERROR;
			end
			M_ERROR: begin
				if (is_end) mode_d = M_FIRST;
				else mode_d = M_ERROR;
			end
			default: mode_d = M_ERROR;
		endcase
	end

	always_comb begin
		add_en     = 1'b0;
		add_lo     = off;
		add_hi     = off;
		prev_d     = prev_q;
		err_d      = err_q;
		fin_dash   = 1'b0;
		fin_status = ST_OK;
		unique case (mode_q)
			M_FIRST, M_FIRST_ESC, M_MAIN_ESC, M_MAIN: begin
				if (is_end) begin
					if (mode_q == M_FIRST) fin_status = ST_INVALID;
					else if (mode_q == M_MAIN) fin_status = ST_OK;
					else fin_status = ST_DANGLING;
				end else if ((mode_q == M_FIRST || mode_q == M_MAIN) && is_esc) begin
					add_en = 1'b0;
				end else if (mode_q == M_MAIN && is_dash) begin
					add_en = 1'b0;
				end else if (is_print) begin
					add_en = 1'b1;
					prev_d = off;
				end else begin
					err_d = ST_INVALID;
				end
			end
			M_DASH1, M_DASHN, M_RANGE_ESC: begin
				if (is_end) begin
					if (mode_q == M_RANGE_ESC) fin_status = ST_DANGLING;
					else fin_dash = 1'b1;
				end else if (mode_q != M_RANGE_ESC && is_dash) begin
					add_en = (mode_q == M_DASH1);
					add_lo = DASH_OFF;
					add_hi = DASH_OFF;
				end else if (mode_q != M_RANGE_ESC && is_esc) begin
					add_en = 1'b0;
				end else if (!is_print) begin
					err_d = ST_INVALID;
				end else if (reversed) begin
					err_d = ST_REVERSED;
				end else begin
					add_en = 1'b1;
					add_lo = prev_q;
					prev_d = off;
				end
			end
			M_ERROR: begin
				if (is_end) fin_status = err_q;
			end
			default: fin_status = err_q;
		endcase

		members_d = add_en ? (members_q | range_mask(add_lo, add_hi)) : members_q;
		fin_set   = members_q | (fin_dash ? range_mask(DASH_OFF, DASH_OFF) : '0);

		if (is_end) begin
			members_d = '0;
			prev_d    = '0;
			err_d     = ST_OK;
		end
	end

	always_comb begin
		result.status = fin_status;
		if (fin_status == ST_OK) begin
			result.set_low      = fin_set[LOW_W-1:0];
			result.set_high     = fin_set[SET_W-1:LOW_W];
			result.member_count = count_members(fin_set);
		end else begin
			result.set_low      = '0;
			result.set_high     = '0;
			result.member_count = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_FIRST;
			members_q <= '0;
			prev_q    <= '0;
			err_q     <= ST_OK;
		end else if (step) begin
			mode_q    <= mode_d;
			members_q <= members_d;
			prev_q    <= prev_d;
			err_q     <= err_d;
		end
	end

	`CCSC_ASSERT(a_end_restarts, clk, arst_n, step && is_end |=> mode_q == M_FIRST, "Spec end did not restart the parser")
	`CCSC_ASSERT(a_first_is_clear, clk, arst_n, mode_q == M_FIRST |-> members_q == '0 && prev_q == '0, "Parser holds members at the start of a spec")
	`CCSC_ASSERT(a_error_is_empty, clk, arst_n, finish && result.status != ST_OK |-> result.member_count == '0 && result.set_low == '0 && result.set_high == '0, "Failed spec reported members")

endmodule

>>> hw/rtl/ccsc_result_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ccsc_result_reg
	import ccsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	output logic    set_valid,
	input  logic    set_stall,
	output result_t held
);

	logic    valid_q;
	result_t result_q;

	assign free      = !valid_q || !set_stall;
	assign set_valid = valid_q;
	assign held      = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!set_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

>>> hw/rtl/char_class_spec_compiler.sv
// ----------------------------------------------------------------------------
// Character class spec compiler
// Compiles a character-set spec into a 94-bit membership set over '!'..'~'.
// ----------------------------------------------------------------------------
// The code channel takes one 16-bit code unit per word; a zero unit ends the
// spec. Each spec yields exactly one result word on the set channel: the set
// split into set_low and set_high, the member count and a status. Units other
// than the terminator give no result.
// A unit is taken into an input register and parsed from there. Its result,
// if any, is loaded into the result register at the end of the cycle in which
// it is parsed; set_valid rises when that register is loaded.
// Throughput is one unit per cycle while code_stall is low: parsing is a
// single pass of logic between the input register and the parse state, with
// the range mask built from the previous offset and the new character.
// While the receiver stalls with a result held, units that give no result
// still flow; a terminator waits in the input register and code_stall rises.
// Reset empties both registers and returns the parser to the start of a spec.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_class_spec_compiler
	import ccsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                code_valid,
	output logic                code_stall,
	input  logic [UNIT_W-1:0]   code_unit,
	output logic                set_valid,
	input  logic                set_stall,
	output logic [LOW_W-1:0]    set_low,
	output logic [HIGH_W-1:0]   set_high,
	output logic [CNT_W-1:0]    member_count,
	output logic [1:0]          status
);

	logic              valid_s1;
	logic [UNIT_W-1:0] code_unit_s1;
	logic              finish, free, advance, take;
	result_t           result, held;

	assign advance    = valid_s1 && (!finish || free);
	assign code_stall = valid_s1 && !advance;
	assign take       = code_valid && !code_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_unit_s1 <= code_unit;
		end
	end

	ccsc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.code_unit (code_unit_s1),
		.finish    (finish),
		.result    (result)
	);

	ccsc_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && finish),
		.result    (result),
		.free      (free),
		.set_valid (set_valid),
		.set_stall (set_stall),
		.held      (held)
	);

	assign set_low      = held.set_low;
	assign set_high     = held.set_high;
	assign member_count = held.member_count;
	assign status       = held.status;

	`CCSC_NEVER(a_stall_needs_word, clk, arst_n, code_stall && !valid_s1, "Input stalled with an empty input register")
	`CCSC_NEVER(a_no_overwrite, clk, arst_n, advance && finish && set_valid && set_stall, "Result register overwritten while stalled")
	`CCSC_ASSERT(a_plain_unit_flows, clk, arst_n, valid_s1 && !finish |-> !code_stall, "A unit without result was held back")

endmodule
